>>> rtl/rpsc_pkg.sv
// Package for the ramped PI speed controller.
// Holds field widths, register indexes and reset values; depends on nothing.
`default_nettype none

package rpsc_pkg;

	// Field widths of the request, result and configuration channels.
	localparam int RPM_W  = 17;
	localparam int GAIN_W = 16;
	localparam int DUTY_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Default number of fraction bits held by the integrator.
	localparam int INT_FRAC_BITS_DEF = 16;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_GAIN    = 2'd0,
		REG_KI_DT_GAIN = 2'd1,
		REG_RAMP_STEP  = 2'd2,
		REG_DUTY_MAX   = 2'd3
	} cfg_reg_t;

	// Reset values of the configuration registers.
	localparam logic [GAIN_W-1:0] KP_GAIN_RST    = 16'd0;
	localparam logic [GAIN_W-1:0] KI_DT_GAIN_RST = 16'd0;
	localparam logic [GAIN_W-1:0] RAMP_STEP_RST  = 16'd1;
	localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = 16'hFFFF;

endpackage

`default_nettype wire

>>> rtl/rpsc_tick_if.sv
// Request channel carrying one control tick (target, measured speed, enable).
// Depends on rpsc_pkg for field widths.
`default_nettype none

interface rpsc_tick_if;
	import rpsc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [RPM_W-1:0] target_rpm;
	logic signed [RPM_W-1:0] measured_rpm;
	logic                    loop_enable;

	modport source (output valid, target_rpm, measured_rpm, loop_enable, input ready);
	modport sink   (input valid, target_rpm, measured_rpm, loop_enable, output ready);
endinterface

`default_nettype wire

>>> rtl/rpsc_duty_if.sv
// Result channel carrying the PWM duty count.
// Depends on rpsc_pkg for field widths.
`default_nettype none

interface rpsc_duty_if;
	import rpsc_pkg::*;

	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] duty_count;

	modport source (output valid, duty_count, input ready);
	modport sink   (input valid, duty_count, output ready);
endinterface

`default_nettype wire

>>> rtl/rpsc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on rpsc_pkg for field widths.
`default_nettype none

interface rpsc_cfg_if;
	import rpsc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/ramped_pi_speed_controller.sv
// Top level of the ramped PI speed controller with anti-windup clamp.
// Depends on rpsc_pkg and the rpsc_tick_if, rpsc_duty_if and rpsc_cfg_if interfaces.
`default_nettype none

// One request is taken per clock cycle unless the result channel stalls. A
// request is captured in an input register; once the result register is
// free, the ramp, the error, both gain products, the integrator update and
// the output clamp are evaluated and written to the result register together
// with the new ramped reference and integrator, so a result is offered from
// the result register and back-to-back requests see each other's state
// without a gap. The loop through the ramp register, the two 17x18
// multipliers and the integrator clamp sets the clock period. Configuration
// writes are always accepted and take effect from the next request onwards.
module ramped_pi_speed_controller #(
	parameter int INTEGRATOR_FRAC_BITS = rpsc_pkg::INT_FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	rpsc_tick_if.sink   tick,
	rpsc_duty_if.source duty,
	rpsc_cfg_if.sink    cfg
);

	import rpsc_pkg::*;

	localparam int FB    = INTEGRATOR_FRAC_BITS;
	localparam int IW    = DUTY_W + FB;
	localparam int ERR_W = RPM_W + 1;
	localparam int PRD_W = GAIN_W + 1 + ERR_W;
	localparam int SW    = FB + 29;
	localparam int ISH_L = (FB >= 16) ? FB - 16 : 0;
	localparam int ISH_R = (FB >= 16) ? 0 : 16 - FB;

	// Configuration registers.
	logic [GAIN_W-1:0] kp_gain_q;
	logic [GAIN_W-1:0] ki_dt_gain_q;
	logic [GAIN_W-1:0] ramp_step_q;
	logic [DUTY_W-1:0] duty_max_q;

	// Controller state.
	logic signed [RPM_W-1:0] ramped_reference_q;
	logic [IW-1:0]           integrator_q;

	// Input register.
	logic                    vld_s1;
	logic signed [RPM_W-1:0] target_s1;
	logic signed [RPM_W-1:0] measured_s1;
	logic                    enable_s1;

	// Result register.
	logic              out_vld_q;
	logic [DUTY_W-1:0] duty_q;

	// Datapath signals.
	logic                    adv_s1;
	logic signed [ERR_W-1:0] diff;
	logic signed [ERR_W-1:0] step_s;
	logic signed [ERR_W-1:0] ramp_sum;
	logic signed [RPM_W-1:0] ramp_nxt;
	logic signed [ERR_W-1:0] err;
	logic signed [PRD_W-1:0] p_prod;
	logic signed [PRD_W-1:0] ki_prod;
	logic signed [SW-1:0]    p_scaled;
	logic signed [SW-1:0]    i_step;
	logic signed [SW-1:0]    i_sum;
	logic signed [SW-1:0]    limit_s;
	logic signed [SW-1:0]    pi_sum;
	logic [IW-1:0]           integ_nxt;
	logic [DUTY_W-1:0]       duty_nxt;

	// Handshakes: the input register moves on whenever the result register is free.
	assign cfg.ready  = 1'b1;
	assign adv_s1     = !out_vld_q || duty.ready;
	assign tick.ready = !vld_s1 || adv_s1;
	assign duty.valid      = out_vld_q;
	assign duty.duty_count = duty_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_gain_q    <= KP_GAIN_RST;
			ki_dt_gain_q <= KI_DT_GAIN_RST;
			ramp_step_q  <= RAMP_STEP_RST;
			duty_max_q   <= DUTY_MAX_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_KP_GAIN:    kp_gain_q    <= cfg.data;
				REG_KI_DT_GAIN: ki_dt_gain_q <= cfg.data;
				REG_RAMP_STEP:  ramp_step_q  <= cfg.data;
				REG_DUTY_MAX:   duty_max_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			target_s1   <= tick.target_rpm;
			measured_s1 <= tick.measured_rpm;
			enable_s1   <= tick.loop_enable;
		end
	end

	// Ramp the reference towards the target by at most one step.
	always_comb begin
		diff   = ERR_W'(target_s1) - ERR_W'(ramped_reference_q);
		step_s = $signed({2'b00, ramp_step_q});
		if (diff > step_s) begin
			ramp_sum = ERR_W'(ramped_reference_q) + step_s;
		end else if (diff < -step_s) begin
			ramp_sum = ERR_W'(ramped_reference_q) - step_s;
		end else begin
			ramp_sum = ERR_W'(target_s1);
		end
		ramp_nxt = ramp_sum[RPM_W-1:0];
		err      = ERR_W'(ramp_nxt) - ERR_W'(measured_s1);
	end

	// Gain products; the integral step is floored when fraction bits are dropped.
	always_comb begin
		p_prod   = $signed({1'b0, kp_gain_q}) * err;
		ki_prod  = $signed({1'b0, ki_dt_gain_q}) * err;
		p_scaled = SW'(p_prod) <<< (FB - 8);
		i_step   = (SW'(ki_prod) <<< ISH_L) >>> ISH_R;
		limit_s  = $signed(SW'({duty_max_q, {FB{1'b0}}}));
	end

	// Integrator update with clamp to zero..duty_max.
	always_comb begin
		i_sum = $signed(SW'(integrator_q)) + i_step;
		if (i_sum > limit_s) begin
			integ_nxt = limit_s[IW-1:0];
		end else if (i_sum[SW-1]) begin
			integ_nxt = '0;
		end else begin
			integ_nxt = i_sum[IW-1:0];
		end
	end

	// Sum of both parts, clamped and truncated to an integer count.
	always_comb begin
		pi_sum = p_scaled + $signed(SW'(integ_nxt));
		if (pi_sum[SW-1]) begin
			duty_nxt = '0;
		end else if (pi_sum > limit_s) begin
			duty_nxt = duty_max_q;
		end else begin
			duty_nxt = pi_sum[FB+DUTY_W-1:FB];
		end
	end

	// State update and result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramped_reference_q <= '0;
			integrator_q       <= '0;
			out_vld_q          <= 1'b0;
		end else begin
			if (adv_s1) begin
				out_vld_q <= vld_s1;
			end
			if (vld_s1 && adv_s1) begin
				if (enable_s1) begin
					ramped_reference_q <= ramp_nxt;
					integrator_q       <= integ_nxt;
				end else begin
					ramped_reference_q <= measured_s1;
					integrator_q       <= '0;
				end
			end
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (vld_s1 && adv_s1) begin
			duty_q <= enable_s1 ? duty_nxt : '0;
		end
	end

`ifndef NO_ASSERTIONS
	// A disabled tick clears the integrator and the duty and loads the measured speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s1 && !enable_s1 |=>
			integrator_q == '0 && duty_q == '0 && ramped_reference_q == $past(measured_s1))
		else $error("disabled tick did not clear the controller state");

	// A produced duty count never exceeds the clamp in force when it was computed.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s1 |=> duty_q <= $past(duty_max_q))
		else $error("duty count above duty_max");

	// A captured request is not lost while the result register is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s1 |=> vld_s1 && $stable(target_s1) && $stable(measured_s1))
		else $error("stalled request dropped from the input register");
`endif

endmodule

`default_nettype wire
